// ===== rtl/dnl_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal number token lexer package
// Shared types and character codes for the numeric token lexer.
// ----------------------------------------------------------------------------
package dnl_pkg;

   // Result status codes.
   typedef enum logic [3:0] {
      ST_UINT      = 4'd0,
      ST_INT       = 4'd1,
      ST_FLOAT     = 4'd2,
      ST_TOO_BIG   = 4'd3,
      ST_TOO_SMALL = 4'd4,
      ST_TWO_DOTS  = 4'd5,
      ST_DOT_EXP   = 4'd6,
      ST_BAD_EXP   = 4'd7,
      ST_MISS_EXP  = 4'd8,
      ST_SECOND_EXP = 4'd9,
      ST_BAD_CHAR  = 4'd10,
      ST_EMPTY     = 4'd11
   } status_type;

   // Lexer phase within one token.
   typedef enum logic [1:0] {
      PH_FIRST = 2'd0,
      PH_BODY  = 2'd1,
      PH_EXP   = 2'd2
   } phase_type;

   localparam int MagWidth = 33;
   localparam int ValWidth = 32;

   // Token state carried between characters.
   typedef struct packed {
      phase_type             phase;
      logic                  negative;
      logic                  seen_dot;
      logic                  seen_exp;
      logic                  seen_body;
      logic [MagWidth-1:0]   mag;
      logic                  mag_ovf;
   } tok_type;

   // One step's outcome, handed from the lexer core to the result register.
   typedef struct packed {
      logic                  emit;
      status_type            status;
      logic [ValWidth-1:0]   value;
   } res_type;

   // Character codes.
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_E_LO   = 8'h65;
   localparam logic [7:0] CH_E_UP   = 8'h45;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;

   // Range limits on the accumulated magnitude.
   localparam logic [MagWidth-1:0] MAG_LIMIT = 33'h1_FFFF_FFFF;
   localparam logic [MagWidth-1:0] U32_MAXV  = 33'h0_FFFF_FFFF;
   localparam logic [MagWidth-1:0] NEG_LIMIT = 33'h0_8000_0000;

endpackage

// ===== rtl/dnl_req_if.sv =====
// ----------------------------------------------------------------------------
// Character request channel
// Valid/ready channel that carries one text character per item.
// ----------------------------------------------------------------------------
interface dnl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       line_end;

   modport source (output valid, output ch, output line_end, input ready);
   modport sink   (input valid, input ch, input line_end, output ready);
endinterface

// ===== rtl/dnl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Token response channel
// Valid/ready channel that carries one lexed token result per item.
// ----------------------------------------------------------------------------
interface dnl_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [31:0] value;

   modport source (output valid, output status, output value, input ready);
   modport sink   (input valid, input status, input value, output ready);
endinterface

// ===== rtl/dnl_core.sv =====
// ----------------------------------------------------------------------------
// Lexer core
// Holds the token state and works out one character step per enabled cycle.
// ----------------------------------------------------------------------------
module dnl_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [7:0]       ch,
   input  logic             line_end,
   output dnl_pkg::res_type res
);

   dnl_pkg::tok_type                      tok_ff;
   dnl_pkg::tok_type                      tok_in;
   dnl_pkg::tok_type                      tok_clear;
   logic                                  is_digit;
   logic                                  is_sign;
   logic                                  is_term;
   logic [dnl_pkg::MagWidth+3:0]          mag_next;
   dnl_pkg::status_type                   fin_status;
   logic [dnl_pkg::ValWidth-1:0]          fin_value;

   // Character classes.
   always_comb begin
      is_digit = (ch >= dnl_pkg::CH_ZERO) && (ch <= dnl_pkg::CH_NINE);
      is_sign  = (ch == dnl_pkg::CH_PLUS) || (ch == dnl_pkg::CH_MINUS);
      is_term  = (ch == dnl_pkg::CH_SPACE) ||
                 ((ch >= dnl_pkg::CH_TAB) && (ch <= dnl_pkg::CH_CR)) ||
                 (ch == dnl_pkg::CH_COMMA) || (ch == dnl_pkg::CH_RBRACK) ||
                 (ch == dnl_pkg::CH_RBRACE) || (ch == dnl_pkg::CH_DQUOTE) ||
                 (ch == dnl_pkg::CH_SQUOTE);
   end

   // Multiply-by-ten accumulate as two shifted adds.
   assign mag_next = {1'b0, tok_ff.mag, 3'b000} + {3'b000, tok_ff.mag, 1'b0} +
                     {{(dnl_pkg::MagWidth){1'b0}}, ch[3:0] - dnl_pkg::CH_ZERO[3:0]};

   // Result of a token that ends normally.
   always_comb begin
      fin_status = dnl_pkg::ST_UINT;
      fin_value  = tok_ff.mag[dnl_pkg::ValWidth-1:0];
      if (!tok_ff.seen_body) begin
         fin_status = dnl_pkg::ST_EMPTY;
         fin_value  = '0;
      end else if (tok_ff.seen_dot || tok_ff.seen_exp) begin
         fin_status = dnl_pkg::ST_FLOAT;
         fin_value  = '0;
      end else if (tok_ff.negative) begin
         if (tok_ff.mag_ovf || (tok_ff.mag > dnl_pkg::NEG_LIMIT)) begin
            fin_status = dnl_pkg::ST_TOO_SMALL;
            fin_value  = '0;
         end else begin
            fin_status = dnl_pkg::ST_INT;
            fin_value  = ~tok_ff.mag[dnl_pkg::ValWidth-1:0] + 32'd1;
         end
      end else if (tok_ff.mag_ovf || (tok_ff.mag > dnl_pkg::U32_MAXV)) begin
         fin_status = dnl_pkg::ST_TOO_BIG;
         fin_value  = '0;
      end
   end

   // One character step: next token state and any result.
   always_comb begin
      tok_clear  = '{phase: dnl_pkg::PH_FIRST, mag: '0, default: 1'b0};
      tok_in     = tok_ff;
      res.emit   = 1'b0;
      res.status = dnl_pkg::ST_EMPTY;
      res.value  = '0;
      if (tok_ff.phase == dnl_pkg::PH_EXP) begin
         // Right after the exponent marker a sign or digit must follow.
         if (line_end) begin
            res.emit   = 1'b1;
            res.status = dnl_pkg::ST_MISS_EXP;
         end else if (is_sign || is_digit) begin
            tok_in.phase = dnl_pkg::PH_BODY;
         end else begin
            res.emit   = 1'b1;
            res.status = dnl_pkg::ST_BAD_EXP;
         end
      end else if (line_end) begin
         res.emit   = 1'b1;
         res.status = fin_status;
         res.value  = fin_value;
      end else if ((tok_ff.phase == dnl_pkg::PH_FIRST) && is_sign) begin
         tok_in.phase    = dnl_pkg::PH_BODY;
         tok_in.negative = (ch == dnl_pkg::CH_MINUS);
      end else begin
         tok_in.phase = dnl_pkg::PH_BODY;
         if (is_digit) begin
            tok_in.seen_body = 1'b1;
            if (!tok_ff.seen_dot && !tok_ff.seen_exp && !tok_ff.mag_ovf) begin
               if (mag_next > {4'b0000, dnl_pkg::MAG_LIMIT}) begin
                  tok_in.mag_ovf = 1'b1;
               end else begin
                  tok_in.mag = mag_next[dnl_pkg::MagWidth-1:0];
               end
            end
         end else if (ch == dnl_pkg::CH_DOT) begin
            if (tok_ff.seen_dot) begin
               res.emit   = 1'b1;
               res.status = dnl_pkg::ST_TWO_DOTS;
            end else if (tok_ff.seen_exp) begin
               res.emit   = 1'b1;
               res.status = dnl_pkg::ST_DOT_EXP;
            end else begin
               tok_in.seen_dot  = 1'b1;
               tok_in.seen_body = 1'b1;
            end
         end else if ((ch == dnl_pkg::CH_E_LO) || (ch == dnl_pkg::CH_E_UP)) begin
            if (tok_ff.seen_exp) begin
               res.emit   = 1'b1;
               res.status = dnl_pkg::ST_SECOND_EXP;
            end else begin
               tok_in.seen_exp  = 1'b1;
               tok_in.seen_body = 1'b1;
               tok_in.phase     = dnl_pkg::PH_EXP;
            end
         end else if (is_term) begin
            res.emit   = 1'b1;
            res.status = fin_status;
            res.value  = fin_value;
         end else begin
            res.emit   = 1'b1;
            res.status = dnl_pkg::ST_BAD_CHAR;
         end
      end
      // Every result ends the token.
      if (res.emit) begin
         tok_in = tok_clear;
      end
   end

   // Token state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '{phase: dnl_pkg::PH_FIRST, mag: '0, default: 1'b0};
      end else if (step_en) begin
         tok_ff <= tok_in;
      end
   end

endmodule

// ===== rtl/decimal_number_token_lexer_top.sv =====
// ----------------------------------------------------------------------------
// Decimal number token lexer
// Lexes one numeric token from a character stream, one character per item.
// ----------------------------------------------------------------------------
//   Channel   Direction   Payload                   Handshake
//   req_chan  in          ch[7:0], line_end         valid/ready
//   rsp_chan  out         status[3:0], value[31:0]  valid/ready
//
// One character item is accepted per cycle while the step is not stalled.
// An item is held in the input register, then its step updates the token
// state and, when it ends a token, loads the result register. The step
// loop through the token state sets the rate. Reset is synchronous and
// clears the token state and both valid flags. When the result register
// is full and not taken, the step stalls and the input register holds
// one waiting item.
module decimal_number_token_lexer_top (
   input  logic      clock,
   input  logic      reset,
   dnl_req_if.sink   req_chan,
   dnl_rsp_if.source rsp_chan
);

   logic                req_valid_ff;
   logic [7:0]          req_ch_ff;
   logic                req_line_end_ff;
   logic                rsp_valid_ff;
   logic [3:0]          rsp_status_ff;
   logic [31:0]         rsp_value_ff;
   logic                out_free;
   logic                step_en;
   dnl_pkg::res_type    step_res;

   // Flow control: a step runs when an item is held and the result slot
   // can take a result.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step_en        = req_valid_ff && out_free;
   assign req_chan.ready = !req_valid_ff || step_en;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_ch_ff       <= req_chan.ch;
         req_line_end_ff <= req_chan.line_end;
      end
   end

   // Token state and step logic.
   dnl_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .ch       (req_ch_ff),
      .line_end (req_line_end_ff),
      .res      (step_res)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step_en && step_res.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && step_res.emit) begin
         rsp_status_ff <= step_res.status;
         rsp_value_ff  <= step_res.value;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.value  = rsp_value_ff;

endmodule
